>>> hdl/cns_pkg.sv
package cns_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned FieldW = 7;

  localparam logic [FieldW-1:0] SecMax = 7'd59;
  localparam logic [FieldW-1:0] MinMax = 7'd59;
  localparam logic [FieldW-1:0] HourMax = 7'd23;
  localparam logic [FieldW-1:0] FebLeapDays = 7'd29;
  localparam logic [FieldW-1:0] MonthMax = 7'd12;
  localparam logic [YearW:0] YearLimit = 15'd9999;

  // divisibility by 25: y * inverse(25) mod 2^14 <= (2^14 - 1) / 25
  localparam logic [YearW-1:0] Inv25 = 14'd7209;
  localparam logic [YearW-1:0] Div25Lim = 14'd655;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
  } ts_t;

  typedef struct packed {
    logic [YearW-1:0]  next_year;
    logic [FieldW-1:0] next_month;
    logic [FieldW-1:0] next_day;
    logic [FieldW-1:0] next_hour;
    logic [FieldW-1:0] next_minute;
    logic [FieldW-1:0] next_second;
    logic              bad;
  } res_t;

  // days in month, index is month - 1
  function automatic logic [FieldW-1:0] month_days(input logic [3:0] idx);
    logic [FieldW-1:0] len;
    case (idx)
      4'd1:                      len = 7'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 7'd30;
      default:                   len = 7'd31;
    endcase
    return len;
  endfunction

endpackage

>>> hdl/cns_step.sv
module cns_step (
  input  cns_pkg::ts_t  ts_i,
  output cns_pkg::res_t res_o
);

  logic [cns_pkg::FieldW:0]   sec_inc, min_inc, hour_inc, day_inc, mon_inc;
  logic [cns_pkg::YearW:0]    year_inc, year_nx;
  logic                       sec_c, min_c, hour_c, day_c, mon_c;
  logic [cns_pkg::FieldW-1:0] sec_nx, min_nx, hour_nx, day_nx, mon_nx;
  logic [cns_pkg::FieldW-1:0] last;
  logic [3:0]                 mon_m1;
  logic [cns_pkg::YearW-1:0]  y_mul;
  logic                       div25, leap, bad;

  assign y_mul  = ts_i.year * cns_pkg::Inv25;
  assign div25  = (y_mul <= cns_pkg::Div25Lim);
  assign leap   = (ts_i.year[1:0] == 2'b00) && (!div25 || (ts_i.year[3:0] == 4'd0));
  assign mon_m1 = ts_i.month[3:0] - 4'd1;

  always_comb begin
    last = cns_pkg::month_days(mon_m1);
    if ((ts_i.month == 7'd2) && leap) begin
      last = cns_pkg::FebLeapDays;
    end
  end

  assign sec_inc  = {1'b0, ts_i.second} + 8'd1;
  assign sec_c    = sec_inc > {1'b0, cns_pkg::SecMax};
  assign sec_nx   = sec_c ? '0 : sec_inc[cns_pkg::FieldW-1:0];

  assign min_inc  = {1'b0, ts_i.minute} + 8'd1;
  assign min_c    = sec_c && (min_inc > {1'b0, cns_pkg::MinMax});
  assign min_nx   = !sec_c ? ts_i.minute : (min_c ? '0 : min_inc[cns_pkg::FieldW-1:0]);

  assign hour_inc = {1'b0, ts_i.hour} + 8'd1;
  assign hour_c   = min_c && (hour_inc > {1'b0, cns_pkg::HourMax});
  assign hour_nx  = !min_c ? ts_i.hour : (hour_c ? '0 : hour_inc[cns_pkg::FieldW-1:0]);

  assign day_inc  = {1'b0, ts_i.day} + 8'd1;
  assign day_c    = hour_c && (day_inc > {1'b0, last});
  assign day_nx   = !hour_c ? ts_i.day : (day_c ? 7'd1 : day_inc[cns_pkg::FieldW-1:0]);

  assign mon_inc  = {1'b0, ts_i.month} + 8'd1;
  assign mon_c    = day_c && (mon_inc > {1'b0, cns_pkg::MonthMax});
  assign mon_nx   = !day_c ? ts_i.month : (mon_c ? 7'd1 : mon_inc[cns_pkg::FieldW-1:0]);

  assign year_inc = {1'b0, ts_i.year} + 15'd1;
  assign year_nx  = mon_c ? year_inc : {1'b0, ts_i.year};

  assign bad = (ts_i.month == 7'd0) || (ts_i.month > cns_pkg::MonthMax) ||
               (ts_i.day == 7'd0) || (year_nx > cns_pkg::YearLimit);

  always_comb begin
    res_o = '0;
    res_o.bad = bad;
    if (!bad) begin
      res_o.next_year   = year_nx[cns_pkg::YearW-1:0];
      res_o.next_month  = mon_nx;
      res_o.next_day    = day_nx;
      res_o.next_hour   = hour_nx;
      res_o.next_minute = min_nx;
      res_o.next_second = sec_nx;
    end
  end

endmodule

>>> hdl/calendar_next_second.sv
// Channel   Ports                     Handshake
// input     ts_i (cns_pkg::ts_t)      word taken at edge with start_i high, busy_o low
// result    res_o (cns_pkg::res_t)    done_o high one cycle, taken at end of that cycle
//
// One word per cycle; busy_o stays low.
// done_o comes from done_q, which loads from vld_q on the same edge that loads res_q.
// Carry cascade and leap test sit between the input and result registers.
// Reset clears the valid flags only; the receiver cannot stall.
module calendar_next_second (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cns_pkg::ts_t  ts_i,
  output logic          done_o,
  output cns_pkg::res_t res_o
);

  logic          vld_q;
  cns_pkg::ts_t  ts_q;
  cns_pkg::res_t res_d, res_q;
  logic          done_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start_i && !busy_o;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      ts_q <= ts_i;
    end
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  cns_step u_step (
    .ts_i  (ts_q),
    .res_o (res_d)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> hdl/cns_checker.sv
module cns_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input cns_pkg::res_t res_o
);

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && $past(rst_ni, 2)) |-> (done_o == $past(start_i, 2)))
    else $error("result strobe does not follow start by two cycles");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.bad) |-> (res_o.next_year == '0 && res_o.next_month == '0 &&
      res_o.next_day == '0 && res_o.next_hour == '0 &&
      res_o.next_minute == '0 && res_o.next_second == '0))
    else $error("error word has nonzero fields");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.bad) |-> (res_o.next_second <= 7'd59 &&
      res_o.next_month >= 7'd1 && res_o.next_month <= 7'd12 &&
      res_o.next_day != 7'd0 && res_o.next_year <= 14'd9999))
    else $error("good word out of range");

endmodule

bind calendar_next_second cns_checker u_cns_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
